// ===== src/accel_orientation_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// accel_orientation_tracker assertion macros
// concurrent assertion shorthands clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ACCEL_ORIENTATION_TRACKER_MACROS_SVH
`define ACCEL_ORIENTATION_TRACKER_MACROS_SVH

// same-cycle implication
`define AOT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("accel_orientation_tracker: assertion failed");

// next-cycle implication
`define AOT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("accel_orientation_tracker: assertion failed");

`endif

// ===== src/aot_pkg.sv =====
// ----------------------------------------------------------------------------
// aot_pkg
// shared types, codes and reset values of the orientation tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aot_pkg;

	localparam int AXES             = 3;
	localparam int SAMPLE_BITS_DFLT = 16;
	localparam int ORIENT_W         = 3;
	localparam int SRC_W            = 2;
	localparam int NEG_W            = 3;
	localparam int HOLD_W           = 16;
	localparam int MARGIN_W         = 16;
	localparam int TIME_W           = 32;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;

	typedef logic [ORIENT_W-1:0]   orient_t;
	typedef logic [SRC_W-1:0]      src_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	// orientation codes
	localparam orient_t OR_UNKNOWN   = 3'd0;
	localparam orient_t OR_LAND_R    = 3'd1;
	localparam orient_t OR_LAND_L    = 3'd2;
	localparam orient_t OR_PORTRAIT  = 3'd3;
	localparam orient_t OR_PORT_FLIP = 3'd4;
	localparam orient_t OR_FACE_UP   = 3'd5;
	localparam orient_t OR_FACE_DOWN = 3'd6;

	// word kinds
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TAKE   = 1'b1;

	// register indexes
	localparam cfg_idx_t REG_SRC_X  = 3'd0;
	localparam cfg_idx_t REG_SRC_Y  = 3'd1;
	localparam cfg_idx_t REG_SRC_Z  = 3'd2;
	localparam cfg_idx_t REG_NEGATE = 3'd3;
	localparam cfg_idx_t REG_HOLD   = 3'd4;
	localparam cfg_idx_t REG_MARGIN = 3'd5;

	// axis source codes
	localparam src_t SRC_X        = 2'd0;
	localparam src_t SRC_Y        = 2'd1;
	localparam src_t SRC_Z        = 2'd2;
	localparam src_t SRC_FALLBACK = 2'd3;

	localparam logic [NEG_W-1:0]    NEGATE_RST = 3'd0;
	localparam logic [HOLD_W-1:0]   HOLD_RST   = 16'd500;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd200;

endpackage

// ===== src/accel_orientation_tracker.sv =====
// ----------------------------------------------------------------------------
// accel_orientation_tracker
// accelerometer axis remap with debounced portrait/landscape/face detection
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one word per item: action 0 is a
//   sample (accel_x/y/z, now_ms), action 1 takes the pending orientation event
//   output channel (out_valid/out_ready) returns exactly one word per item, in
//   order: the remapped board axes, the settled orientation after the item,
//   and for a take word whether an event was pending and its code
//   configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata), to
//   be written only while the block is idle, which the block does not enforce;
//   writing a source or negate register drops the settled and candidate
//   orientation back to unknown
// path: a word passes the input register, then the result register; the remap,
//   classify and hold compare all sit between them
// throughput: one word per cycle while the output is not held off
// reset: arst_n clears all state and loads the register defaults (identity
//   map, no negation, 500 ms hold, 200 milli-g margin); no words are held
// stall: a held-off output keeps its word; one more word waits in the input
//   register, after which in_ready drops until the output drains
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_orientation_tracker
	import aot_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DFLT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  logic [TIME_W-1:0]             now_ms,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] board_x,
	output logic signed [SAMPLE_BITS-1:0] board_y,
	output logic signed [SAMPLE_BITS-1:0] board_z,
	output logic [ORIENT_W-1:0]           settled_orientation,
	output logic                          event_taken,
	output logic [ORIENT_W-1:0]           taken_orientation
);

	// compare width: magnitude or margin plus one carry bit
	localparam int SUM_W = ((SAMPLE_BITS > MARGIN_W) ? SAMPLE_BITS : MARGIN_W) + 1;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// configuration registers
	src_t                  source_q [AXES];
	logic [NEG_W-1:0]      negate_q;
	logic [HOLD_W-1:0]     hold_q;
	logic [MARGIN_W-1:0]   margin_q;

	// tracking state
	orient_t               settled_q;
	orient_t               candidate_q;
	logic [TIME_W-1:0]     since_q;
	orient_t               pending_q;

	// input register
	logic                          valid_s1;
	logic                          action_s1;
	logic signed [SAMPLE_BITS-1:0] accel_s1 [AXES];
	logic [TIME_W-1:0]             now_s1;

	// result register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] board_q [AXES];
	orient_t                       settled_out_q;
	logic                          event_q;
	orient_t                       taken_q;

	// datapath
	logic signed [SAMPLE_BITS-1:0] board_c [AXES];
	logic [SAMPLE_BITS-1:0]        mag_c [AXES];
	logic [SUM_W-1:0]              mag_ext [AXES];
	logic [SUM_W-1:0]              sum_ext [AXES];
	logic [AXES-1:0]               positive_c;
	logic                          dom_x, dom_y, dom_z;
	orient_t                       seen_c;
	logic [TIME_W-1:0]             elapsed_c;
	logic                          held_c;

	orient_t                       settled_nx;
	orient_t                       candidate_nx;
	logic [TIME_W-1:0]             since_nx;
	orient_t                       pending_nx;
	logic signed [SAMPLE_BITS-1:0] res_board [AXES];
	orient_t                       res_settled;
	logic                          res_event;
	orient_t                       res_taken;

	logic                          advance;
	logic                          in_fire;

	// input register moves into the result register when that one is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// remap, negate with saturation, magnitude
	always_comb begin
		src_t                          src;
		logic signed [SAMPLE_BITS-1:0] v;
		src = SRC_X;
		v   = '0;
		for (int i = 0; i < AXES; i++) begin
			src = source_q[i];
			if (src == SRC_FALLBACK) begin
				v = accel_s1[i];
			end else begin
				v = accel_s1[src];
			end
			if (negate_q[i]) begin
				v = (v == SAMPLE_MIN) ? SAMPLE_MAX : -v;
			end
			board_c[i]    = v;
			mag_c[i]      = v[SAMPLE_BITS-1] ? (-v) : v;
			mag_ext[i]    = {{(SUM_W-SAMPLE_BITS){1'b0}}, mag_c[i]};
			sum_ext[i]    = mag_ext[i] + {{(SUM_W-MARGIN_W){1'b0}}, margin_q};
			positive_c[i] = !v[SAMPLE_BITS-1] && (v != '0);
		end
	end

	// dominant axis must beat both others by the margin
	assign dom_x = (mag_ext[0] >= sum_ext[1]) && (mag_ext[0] >= sum_ext[2]);
	assign dom_y = (mag_ext[1] >= sum_ext[0]) && (mag_ext[1] >= sum_ext[2]);
	assign dom_z = (mag_ext[2] >= sum_ext[0]) && (mag_ext[2] >= sum_ext[1]);

	always_comb begin
		if (dom_x) begin
			seen_c = positive_c[0] ? OR_LAND_R : OR_LAND_L;
		end else if (dom_y) begin
			seen_c = positive_c[1] ? OR_PORTRAIT : OR_PORT_FLIP;
		end else if (dom_z) begin
			seen_c = positive_c[2] ? OR_FACE_UP : OR_FACE_DOWN;
		end else begin
			seen_c = settled_q;
		end
	end

	// wrapping elapsed time since the candidate first appeared
	assign elapsed_c = now_s1 - since_q;
	assign held_c    = elapsed_c >= {{(TIME_W-HOLD_W){1'b0}}, hold_q};

	// next state and result word
	always_comb begin
		settled_nx   = settled_q;
		candidate_nx = candidate_q;
		since_nx     = since_q;
		pending_nx   = pending_q;
		res_settled  = settled_q;
		res_event    = 1'b0;
		res_taken    = OR_UNKNOWN;
		for (int i = 0; i < AXES; i++) begin
			res_board[i] = '0;
		end
		unique case (action_s1)
			ACT_TAKE: begin
				// pending is unknown when nothing waits, so it doubles as the code
				res_event  = (pending_q != OR_UNKNOWN);
				res_taken  = pending_q;
				pending_nx = OR_UNKNOWN;
			end
			ACT_SAMPLE: begin
				for (int i = 0; i < AXES; i++) begin
					res_board[i] = board_c[i];
				end
				if (seen_c != candidate_q) begin
					candidate_nx = seen_c;
					since_nx     = now_s1;
				end else if ((seen_c != settled_q) && held_c) begin
					settled_nx = seen_c;
					pending_nx = seen_c;
				end
				res_settled = settled_nx;
			end
			default: begin
			end
		endcase
	end

	// configuration and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q[0] <= SRC_X;
			source_q[1] <= SRC_Y;
			source_q[2] <= SRC_Z;
			negate_q    <= NEGATE_RST;
			hold_q      <= HOLD_RST;
			margin_q    <= MARGIN_RST;
			settled_q   <= OR_UNKNOWN;
			candidate_q <= OR_UNKNOWN;
			since_q     <= '0;
			pending_q   <= OR_UNKNOWN;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SRC_X: begin
					source_q[0] <= cfg_wdata[SRC_W-1:0];
					settled_q   <= OR_UNKNOWN;
					candidate_q <= OR_UNKNOWN;
				end
				REG_SRC_Y: begin
					source_q[1] <= cfg_wdata[SRC_W-1:0];
					settled_q   <= OR_UNKNOWN;
					candidate_q <= OR_UNKNOWN;
				end
				REG_SRC_Z: begin
					source_q[2] <= cfg_wdata[SRC_W-1:0];
					settled_q   <= OR_UNKNOWN;
					candidate_q <= OR_UNKNOWN;
				end
				REG_NEGATE: begin
					negate_q    <= cfg_wdata[NEG_W-1:0];
					settled_q   <= OR_UNKNOWN;
					candidate_q <= OR_UNKNOWN;
				end
				REG_HOLD:   hold_q   <= cfg_wdata[HOLD_W-1:0];
				REG_MARGIN: margin_q <= cfg_wdata[MARGIN_W-1:0];
				default: begin
				end
			endcase
		end else if (advance) begin
			settled_q   <= settled_nx;
			candidate_q <= candidate_nx;
			since_q     <= since_nx;
			pending_q   <= pending_nx;
		end
	end

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1   <= action;
			accel_s1[0] <= accel_x;
			accel_s1[1] <= accel_y;
			accel_s1[2] <= accel_z;
			now_s1      <= now_ms;
		end
		if (advance) begin
			for (int i = 0; i < AXES; i++) begin
				board_q[i] <= res_board[i];
			end
			settled_out_q <= res_settled;
			event_q       <= res_event;
			taken_q       <= res_taken;
		end
	end

	assign out_valid           = out_valid_q;
	assign board_x             = board_q[0];
	assign board_y             = board_q[1];
	assign board_z             = board_q[2];
	assign settled_orientation = settled_out_q;
	assign event_taken         = event_q;
	assign taken_orientation   = taken_q;

endmodule

// ===== src/aot_checker.sv =====
// ----------------------------------------------------------------------------
// aot_checker
// port-level checks of the orientation tracker, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "accel_orientation_tracker_macros.svh"

module aot_checker
	import aot_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DFLT
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] board_x,
	input logic signed [SAMPLE_BITS-1:0] board_y,
	input logic signed [SAMPLE_BITS-1:0] board_z,
	input logic                          event_taken,
	input logic [ORIENT_W-1:0]           taken_orientation
);

	// result word fields other than the settled orientation, as one vector
	logic [3*SAMPLE_BITS+ORIENT_W:0] out_word;

	assign out_word = {board_x, board_y, board_z, event_taken, taken_orientation};

	// stalled word holds
	`AOT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

	// empty output register means the input side can always move
	`AOT_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

	// event flag and taken code agree
	`AOT_ASSERT_IMP(a_taken_code, out_valid, event_taken == (taken_orientation != OR_UNKNOWN))

	// a take word that returns an event carries no board axes
	`AOT_ASSERT_IMP(a_take_zero_axes, out_valid && event_taken, board_x == '0 && board_y == '0 && board_z == '0)

endmodule

bind accel_orientation_tracker aot_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_aot_checker (.*);
